[design/fdd_pkg.sv]
// ----------------------------------------------------------------------------
// fdd_pkg: shared types and constants of the flip-dot packet engine
// Holds the default geometry, the input function codes, the command passed
// from the front to the back, and the result record.
// ----------------------------------------------------------------------------
package fdd_pkg;

	localparam int DOT_COLUMNS_DEF = 112;
	localparam int DOT_ROWS_DEF = 28;
	localparam logic [31:0] MODULE_MAP_RESET = 32'h8765_4321;

	localparam logic [1:0] FUNC_SET = 2'd0;
	localparam logic [1:0] FUNC_FILL = 2'd1;
	localparam logic [1:0] FUNC_SCAN = 2'd2;

	localparam logic KIND_DOT = 1'b0;
	localparam logic KIND_DISABLE = 1'b1;

	typedef enum logic [1:0] {
		OP_SET,
		OP_FILL,
		OP_SCAN
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] x;
		logic [7:0] y;
		logic       st;
		logic [7:0] fill;
	} cmd_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] module_byte;
		logic [7:0] column_byte;
		logic [7:0] row_byte;
		logic       last;
	} res_t;

	typedef struct packed {
		logic clearing;
	} back_status_t;

endpackage

[design/fdd_if.sv]
// ----------------------------------------------------------------------------
// fdd_if: channel interfaces of the flip-dot packet engine
// Input item channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface fdd_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [7:0] x;
	logic [7:0] y;
	logic       state;
	logic [7:0] fill_value;

	modport source (output valid, func, x, y, state, fill_value, input ready);
	modport sink (input valid, func, x, y, state, fill_value, output ready);
endinterface

interface fdd_out_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] module_byte;
	logic [7:0] column_byte;
	logic [7:0] row_byte;
	logic       last;

	modport source (output valid, kind, module_byte, column_byte, row_byte, last,
		input ready);
	modport sink (input valid, kind, module_byte, column_byte, row_byte, last,
		output ready);
endinterface

interface fdd_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] module_map;

	modport source (output valid, module_map, input ready);
	modport sink (input valid, module_map, output ready);
endinterface

[design/fdd_ram.sv]
// ----------------------------------------------------------------------------
// fdd_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module fdd_ram #(
	parameter int WIDTH = 28,
	parameter int DEPTH = 112,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[design/fdd_front.sv]
// ----------------------------------------------------------------------------
// fdd_front: input decode and command queue
// Accepts input beats, drops the ones that do nothing, and queues the rest
// in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module fdd_front import fdd_pkg::*; #(
	parameter int DOT_COLUMNS = DOT_COLUMNS_DEF,
	parameter int DOT_ROWS = DOT_ROWS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	fdd_in_if.sink       item_in,
	input  back_status_t status,
	output logic         cmd_valid,
	output cmd_t         cmd,
	input  logic         cmd_pop
);

	logic       keep;
	op_t        op;
	logic       push;
	cmd_t       entries_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	always_comb begin
		keep = 1'b0;
		op = OP_SET;
		case (item_in.func)
			FUNC_SET: begin
				op = OP_SET;
				keep = ({1'b0, item_in.x} < 9'(DOT_COLUMNS)) &&
					({1'b0, item_in.y} < 9'(DOT_ROWS));
			end
			FUNC_FILL: begin
				op = OP_FILL;
				keep = 1'b1;
			end
			FUNC_SCAN: begin
				op = OP_SCAN;
				keep = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign item_in.ready = (count_q != 2'd2) && !status.clearing;
	assign push = item_in.valid && item_in.ready && keep;
	assign cmd_valid = (count_q != 2'd0);
	assign cmd = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= '{op: op, x: item_in.x, y: item_in.y,
				st: item_in.state, fill: item_in.fill_value};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(cmd_pop);
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("command queue overfilled");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> count_q != 2'd0)
		else $error("pop from empty command queue");
	a_no_push_clear: assert property (@(posedge clk) disable iff (!arst_n)
		status.clearing |-> !push)
		else $error("command queued during clearing pass");
`endif

endmodule

[design/fdd_back.sv]
// ----------------------------------------------------------------------------
// fdd_back: frame stores and command execution
// Runs set, fill and column scan on the two frame RAMs, builds the driver
// packets a row per cycle unless the output stalls; copies the frame at wrap.
// ----------------------------------------------------------------------------
module fdd_back import fdd_pkg::*; #(
	parameter int DOT_COLUMNS = DOT_COLUMNS_DEF,
	parameter int DOT_ROWS = DOT_ROWS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic [31:0]  module_map,
	input  logic         cmd_valid,
	input  cmd_t         cmd,
	output logic         cmd_pop,
	output back_status_t status,
	fdd_out_if.source    result_out
);

	localparam int CW = $clog2(DOT_COLUMNS);
	localparam int RIW = (DOT_ROWS > 1) ? $clog2(DOT_ROWS) : 1;
	localparam logic [CW-1:0] COL_LAST = CW'(DOT_COLUMNS - 1);
	localparam logic [RIW-1:0] ROW_LAST = RIW'(DOT_ROWS - 1);

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SET_RD,
		ST_SET_WR,
		ST_FILL,
		ST_SCAN_RD,
		ST_SCAN_LAT,
		ST_ROWS,
		ST_DISABLE,
		ST_COPY,
		ST_COPY_END
	} state_t;

	state_t              state_q;
	cmd_t                cmd_q;
	logic [CW-1:0]       idx_q;
	logic [CW-1:0]       wa_q;
	logic [CW-1:0]       col_q;
	logic [2:0]          cm7_q;
	logic [1:0]          cq_q;
	logic [2:0]          cg_q;
	logic [RIW-1:0]      row_q;
	logic [2:0]          r7_q;
	logic                half_q;
	logic                high_q;
	logic                wrap_q;
	logic [DOT_ROWS-1:0] diff_q;
	logic [DOT_ROWS-1:0] curv_q;
	logic                out_v_q;
	res_t                res_q;

	logic                cur_we, cur_re, prev_we, prev_re;
	logic [CW-1:0]       cur_wa, cur_ra, prev_wa, prev_ra;
	logic [DOT_ROWS-1:0] cur_wd, prev_wd, cur_rd, prev_rd, set_mask;

	logic                out_free, out_set, more, st, ns, low;
	logic [4:0]          ca, ra, cr, rr;
	logic [3:0]          entry;
	logic [7:0]          mod_byte;
	res_t                dot_res;

	fdd_ram #(.WIDTH(DOT_ROWS), .DEPTH(DOT_COLUMNS)) u_cur_ram (
		.clk(clk), .we(cur_we), .waddr(cur_wa), .wdata(cur_wd),
		.re(cur_re), .raddr(cur_ra), .rdata(cur_rd)
	);

	fdd_ram #(.WIDTH(DOT_ROWS), .DEPTH(DOT_COLUMNS)) u_prev_ram (
		.clk(clk), .we(prev_we), .waddr(prev_wa), .wdata(prev_wd),
		.re(prev_re), .raddr(prev_ra), .rdata(prev_rd)
	);

	assign set_mask = DOT_ROWS'(1) << cmd_q.y[RIW-1:0];

	always_comb begin
		cur_we = 1'b0;
		cur_re = 1'b0;
		prev_we = 1'b0;
		prev_re = 1'b0;
		cur_wa = idx_q;
		cur_ra = idx_q;
		prev_wa = idx_q;
		prev_ra = col_q;
		cur_wd = '0;
		prev_wd = '0;
		case (state_q)
			ST_CLEAR: begin
				cur_we = 1'b1;
				prev_we = 1'b1;
			end
			ST_SET_RD: begin
				cur_re = 1'b1;
				cur_ra = cmd_q.x[CW-1:0];
			end
			ST_SET_WR: begin
				cur_we = 1'b1;
				cur_wa = cmd_q.x[CW-1:0];
				cur_wd = cmd_q.st ? (cur_rd | set_mask) : (cur_rd & ~set_mask);
			end
			ST_FILL: begin
				cur_we = 1'b1;
				cur_wd = {DOT_ROWS{cmd_q.fill[~idx_q[2:0]]}};
			end
			ST_SCAN_RD: begin
				cur_re = 1'b1;
				prev_re = 1'b1;
				cur_ra = col_q;
			end
			ST_COPY: begin
				cur_re = 1'b1;
				prev_we = (idx_q != '0);
				prev_wa = wa_q;
				prev_wd = cur_rd;
			end
			ST_COPY_END: begin
				prev_we = 1'b1;
				prev_wa = wa_q;
				prev_wd = cur_rd;
			end
			default: begin
				cur_we = 1'b0;
			end
		endcase
	end

	// Packet fields come straight from the column and row counters.
	always_comb begin
		st = curv_q[0];
		ns = !st;
		low = !high_q;
		ca = {cq_q, cm7_q + 3'd1};
		ra = {half_q, ns, r7_q + 3'd1};
		cr = {ca[0], ca[1], ca[2], ca[3], ca[4]};
		rr = {ra[3], ra[4], ra[0], ra[1], ra[2]};
		entry = module_map[{cg_q, 2'b00} +: 4];
		if (entry >= 4'd1 && entry <= 4'd8) begin
			mod_byte = ~(8'h80 >> (entry - 4'd1));
		end else begin
			mod_byte = 8'hFF;
		end
		more = |(diff_q >> 1);
		dot_res.kind = KIND_DOT;
		dot_res.module_byte = mod_byte;
		dot_res.column_byte = {rr[0], ns, cr, 1'b0};
		dot_res.row_byte = {!low, st, low, st, rr[4:1]};
		dot_res.last = !more && !wrap_q;
	end

	assign out_free = !out_v_q || result_out.ready;
	// The output register loads a dot packet or the disable beat this cycle.
	assign out_set = out_free &&
		((state_q == ST_ROWS && diff_q[0]) || (state_q == ST_DISABLE));
	assign cmd_pop = (state_q == ST_IDLE) && cmd_valid;
	assign status.clearing = (state_q == ST_CLEAR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cmd_q <= '{op: OP_SET, x: 8'd0, y: 8'd0, st: 1'b0, fill: 8'd0};
			idx_q <= '0;
			wa_q <= '0;
			col_q <= '0;
			cm7_q <= '0;
			cq_q <= '0;
			cg_q <= '0;
			row_q <= '0;
			r7_q <= '0;
			half_q <= 1'b0;
			high_q <= 1'b0;
			wrap_q <= 1'b0;
			diff_q <= '0;
			curv_q <= '0;
			out_v_q <= 1'b0;
			res_q <= '0;
		end else begin
			if (out_set) begin
				out_v_q <= 1'b1;
			end else if (result_out.ready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					idx_q <= idx_q + CW'(1);
					if (idx_q == COL_LAST) begin
						idx_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd_valid) begin
						cmd_q <= cmd;
						idx_q <= '0;
						case (cmd.op)
							OP_SET: state_q <= ST_SET_RD;
							OP_FILL: state_q <= ST_FILL;
							OP_SCAN: begin
								state_q <= ST_SCAN_RD;
								wrap_q <= (col_q == COL_LAST);
								row_q <= '0;
								r7_q <= '0;
								half_q <= 1'b0;
								high_q <= 1'b0;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_SET_RD: state_q <= ST_SET_WR;
				ST_SET_WR: state_q <= ST_IDLE;
				ST_FILL: begin
					idx_q <= idx_q + CW'(1);
					if (idx_q == COL_LAST) begin
						idx_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN_RD: state_q <= ST_SCAN_LAT;
				ST_SCAN_LAT: begin
					diff_q <= cur_rd ^ prev_rd;
					curv_q <= cur_rd;
					state_q <= ST_ROWS;
				end
				ST_ROWS: begin
					if (!diff_q[0] || out_free) begin
						if (diff_q[0]) begin
							res_q <= dot_res;
						end
						diff_q <= diff_q >> 1;
						curv_q <= curv_q >> 1;
						row_q <= row_q + RIW'(1);
						if (r7_q == 3'd6) begin
							r7_q <= 3'd0;
							if (half_q) begin
								half_q <= 1'b0;
								high_q <= 1'b1;
							end else begin
								half_q <= 1'b1;
							end
						end else begin
							r7_q <= r7_q + 3'd1;
						end
						if (row_q == ROW_LAST) begin
							if (wrap_q) begin
								col_q <= '0;
								cm7_q <= '0;
								cq_q <= '0;
								cg_q <= '0;
								state_q <= ST_DISABLE;
							end else begin
								col_q <= col_q + CW'(1);
								if (cm7_q == 3'd6) begin
									cm7_q <= 3'd0;
									cq_q <= cq_q + 2'd1;
									if (cq_q == 2'd3) begin
										cg_q <= cg_q + 3'd1;
									end
								end else begin
									cm7_q <= cm7_q + 3'd1;
								end
								state_q <= ST_IDLE;
							end
						end
					end
				end
				ST_DISABLE: begin
					if (out_free) begin
						res_q <= '{kind: KIND_DISABLE, module_byte: 8'hFF,
							column_byte: 8'h00, row_byte: 8'h00, last: 1'b1};
						idx_q <= '0;
						state_q <= ST_COPY;
					end
				end
				ST_COPY: begin
					idx_q <= idx_q + CW'(1);
					wa_q <= idx_q;
					if (idx_q == COL_LAST) begin
						state_q <= ST_COPY_END;
					end
				end
				ST_COPY_END: begin
					idx_q <= '0;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result_out.valid = out_v_q;
	assign result_out.kind = res_q.kind;
	assign result_out.module_byte = res_q.module_byte;
	assign result_out.column_byte = res_q.column_byte;
	assign result_out.row_byte = res_q.row_byte;
	assign result_out.last = res_q.last;

`ifndef SYNTHESIS
	a_disable_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && res_q.kind == KIND_DISABLE |-> res_q.last && res_q.module_byte == 8'hFF)
		else $error("disable result malformed");
	a_disable_copy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DISABLE && out_free |=> state_q == ST_COPY)
		else $error("frame copy did not follow disable result");
	a_row_stall: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROWS && diff_q[0] && !out_free |=> $stable(diff_q) && $stable(row_q))
		else $error("row scan advanced while output stalled");
`endif

endmodule

[design/flip_dot_diff_packet_engine.sv]
// ----------------------------------------------------------------------------
// flip_dot_diff_packet_engine: flip-dot frame difference packet engine
// Holds a current and a previous dot frame and turns changed dots of one
// scan column into three-byte driver packets.
// ----------------------------------------------------------------------------
// Usage: item_in carries one command per beat: set dot, fill with a byte
// pattern, or scan one column. result_out carries driver packets, each with
// last set on the final result of its command. cfg writes the module map and
// is always ready; write it only while the block is idle.
// A set dot and a fill yield no results. A column scan makes one frame-RAM
// column read and then checks one row per cycle unless the output stalls;
// a changed dot loads a packet into the output register. On the column that
// wraps, a disable-all result follows, and the current frame is copied into
// the previous one, one column a cycle through the RAM port.
// A two-entry command queue lets input beats arrive while a command runs.
// After reset both frames are cleared in one pass over all columns, and
// item_in is held not ready during that pass. When the receiver stalls, the
// row scan holds on the changed dot until the output register frees up.
// ----------------------------------------------------------------------------
module flip_dot_diff_packet_engine import fdd_pkg::*; #(
	parameter int DOT_COLUMNS = DOT_COLUMNS_DEF,
	parameter int DOT_ROWS = DOT_ROWS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	fdd_in_if.sink    item_in,
	fdd_out_if.source result_out,
	fdd_cfg_if.sink   cfg
);

	// Module map register: one nibble per 28-column group.
	logic [31:0]  module_map_q;

	// Command hand-off between front and back.
	logic         cmd_valid;
	cmd_t         cmd;
	logic         cmd_pop;
	back_status_t status;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			module_map_q <= MODULE_MAP_RESET;
		end else if (cfg.valid) begin
			module_map_q <= cfg.module_map;
		end
	end

	// The front decodes beats and queues the commands that have an effect.
	fdd_front #(.DOT_COLUMNS(DOT_COLUMNS), .DOT_ROWS(DOT_ROWS)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.item_in(item_in),
		.status(status),
		.cmd_valid(cmd_valid),
		.cmd(cmd),
		.cmd_pop(cmd_pop)
	);

	// The back owns the frame RAMs, the scan column and the output register.
	fdd_back #(.DOT_COLUMNS(DOT_COLUMNS), .DOT_ROWS(DOT_ROWS)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.module_map(module_map_q),
		.cmd_valid(cmd_valid),
		.cmd(cmd),
		.cmd_pop(cmd_pop),
		.status(status),
		.result_out(result_out)
	);

endmodule

[sim/fdd_scoreboard.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdd_scoreboard: packet predictor and checker for the flip-dot engine
// Mirrors both dot frames, the scan column and the module map, expands each
// accepted command into the driver packets it should cause, and checks the
// packets that come out against them in order.
// ----------------------------------------------------------------------------
class fdd_scoreboard;
	localparam int COLS = fdd_pkg::DOT_COLUMNS_DEF;
	localparam int ROWS = fdd_pkg::DOT_ROWS_DEF;

	logic [31:0] module_map;
	logic [ROWS-1:0] cur_frame [COLS];
	logic [ROWS-1:0] prev_frame [COLS];
	int scan_col;
	fdd_pkg::res_t pending_packets [$];
	int errors;

	function void reset_state();
		module_map = fdd_pkg::MODULE_MAP_RESET;
		foreach (cur_frame[c]) begin
			cur_frame[c] = '0;
			prev_frame[c] = '0;
		end
		scan_col = 0;
		pending_packets.delete();
		errors = 0;
	endfunction

	function void write_map(logic [31:0] value);
		module_map = value;
	endfunction

	function fdd_pkg::res_t make_dot_packet(int x, int y, logic st);
		fdd_pkg::res_t p;
		logic [3:0] entry;
		logic [7:0] sel;
		logic [7:0] rev;
		logic ns;
		logic [4:0] ca;
		logic [4:0] ra;
		logic [4:0] cr;
		logic [4:0] rr;
		logic low;
		entry = module_map[4 * ((x / 28) % 8) +: 4];
		sel = (entry >= 1 && entry <= 8) ? 8'(1 << (entry - 1)) : 8'h00;
		for (int i = 0; i < 8; i++)
			rev[7 - i] = sel[i];
		ns = ~st;
		ca = 5'((((x % 28) / 7) << 3) | (x % 7 + 1));
		ra = 5'(((((y % 14) / 7) * 2 + ns) << 3) | (y % 7 + 1));
		low = (y < 14);
		// Column and row address lines are wired in a scrambled order on the board.
		cr = {ca[0], ca[1], ca[2], ca[3], ca[4]};
		rr = {ra[3], ra[4], ra[0], ra[1], ra[2]};
		p.kind = fdd_pkg::KIND_DOT;
		p.module_byte = ~rev;
		p.column_byte = {rr[0], ns, cr, 1'b0};
		p.row_byte = {~low, st, low, st, rr[4:1]};
		p.last = 1'b0;
		return p;
	endfunction

	// Notes one accepted command and queues the packets it should cause.
	function void note_command(logic [1:0] func, logic [7:0] x, logic [7:0] y,
		logic st, logic [7:0] fill);
		int n;
		fdd_pkg::res_t p;
		n = 0;
		if (func == fdd_pkg::FUNC_SET) begin
			if (x < COLS && y < ROWS)
				cur_frame[x][y] = st;
		end else if (func == fdd_pkg::FUNC_FILL) begin
			foreach (cur_frame[c])
				cur_frame[c] = fill[7 - (c % 8)] ? '1 : '0;
		end else if (func == fdd_pkg::FUNC_SCAN) begin
			for (int r = 0; r < ROWS; r++) begin
				if (cur_frame[scan_col][r] != prev_frame[scan_col][r]) begin
					pending_packets.push_back(make_dot_packet(scan_col, r,
						cur_frame[scan_col][r]));
					n++;
				end
			end
			scan_col++;
			if (scan_col >= COLS) begin
				scan_col = 0;
				p = '{kind: fdd_pkg::KIND_DISABLE, module_byte: 8'hFF,
					column_byte: 8'h00, row_byte: 8'h00, last: 1'b0};
				pending_packets.push_back(p);
				n++;
				prev_frame = cur_frame;
			end
			if (n > 0)
				pending_packets[$].last = 1'b1;
		end
	endfunction

	function void check_packet(fdd_pkg::res_t got);
		fdd_pkg::res_t want;
		if (pending_packets.size() == 0) begin
			$display("%0t: unexpected packet %h", $time, got);
			errors++;
			return;
		end
		want = pending_packets.pop_front();
		if (got.kind !== want.kind) begin
			$display("%0t: kind expected %h actual %h", $time, want.kind, got.kind);
			errors++;
		end
		if (got.module_byte !== want.module_byte) begin
			$display("%0t: module_byte expected %h actual %h", $time,
				want.module_byte, got.module_byte);
			errors++;
		end
		if (got.column_byte !== want.column_byte) begin
			$display("%0t: column_byte expected %h actual %h", $time,
				want.column_byte, got.column_byte);
			errors++;
		end
		if (got.row_byte !== want.row_byte) begin
			$display("%0t: row_byte expected %h actual %h", $time,
				want.row_byte, got.row_byte);
			errors++;
		end
		if (got.last !== want.last) begin
			$display("%0t: last expected %h actual %h", $time, want.last, got.last);
			errors++;
		end
	endfunction
endclass

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench of the flip-dot difference packet engine
// Drives set, fill and scan commands with random idling on both sides,
// predicts every driver packet in a scoreboard and checks each result beat.
// ----------------------------------------------------------------------------
module testbench;
	import fdd_pkg::*;

	localparam int COLS = DOT_COLUMNS_DEF;
	localparam int ROWS = DOT_ROWS_DEF;
	// Longest quiet stretch: reset clearing, a wrap copy, and stalls.
	localparam int WATCHDOG_LIMIT = 4000;
	// A wrap copy can run this long after the disable beat has come.
	localparam int SETTLE_CYCLES = COLS + 40;

	logic clk;
	logic arst_n;

	fdd_in_if item_in ();
	fdd_out_if result_out ();
	fdd_cfg_if cfg ();

	flip_dot_diff_packet_engine u_top (
		.clk(clk),
		.arst_n(arst_n),
		.item_in(item_in),
		.result_out(result_out),
		.cfg(cfg)
	);

	fdd_scoreboard packet_board;
	// When set, the sender and receiver never idle (the final stretch).
	bit no_idle;
	int quiet_cycles = 0;
	int checked_beats = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The receiver stalls in random bursts, with stretches of no stall.
	initial begin
		int stall;
		result_out.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!no_idle && $urandom_range(0, 9) == 0) begin
				result_out.ready <= 1'b0;
				stall = $urandom_range(1, 11);
				repeat (stall - 1) @(posedge clk);
			end else begin
				result_out.ready <= 1'b1;
			end
		end
	end

	// Every result beat is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && result_out.valid && result_out.ready) begin
			packet_board.check_packet('{kind: result_out.kind,
				module_byte: result_out.module_byte,
				column_byte: result_out.column_byte,
				row_byte: result_out.row_byte, last: result_out.last});
			checked_beats++;
		end
	end

	// The watchdog counts cycles in which no beat moves on either channel.
	always @(posedge clk) begin
		if ((item_in.valid && item_in.ready) || (result_out.valid && result_out.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Sends one command beat and holds it until the block accepts it. Valid
	// stays high into the next command unless an idle burst comes between.
	task automatic send_command(logic [1:0] func, logic [7:0] x, logic [7:0] y,
		logic st, logic [7:0] fill);
		int gap;
		if (!no_idle && $urandom_range(0, 7) == 0) begin
			item_in.valid <= 1'b0;
			gap = $urandom_range(1, 11);
			repeat (gap) @(posedge clk);
		end
		item_in.valid <= 1'b1;
		item_in.func <= func;
		item_in.x <= x;
		item_in.y <= y;
		item_in.state <= st;
		item_in.fill_value <= fill;
		do
			@(posedge clk);
		while (!item_in.ready);
		packet_board.note_command(func, x, y, st, fill);
	endtask

	// Lowers valid, waits for every predicted packet and for any trailing
	// frame copy, so that the block is idle.
	task automatic drain_block();
		item_in.valid <= 1'b0;
		@(posedge clk);
		while (packet_board.pending_packets.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_module_map(logic [31:0] value);
		cfg.valid <= 1'b1;
		cfg.module_map <= value;
		do
			@(posedge clk);
		while (!cfg.ready);
		cfg.valid <= 1'b0;
		packet_board.write_map(value);
	endtask

	// Scans a full frame so that a wrap is reached.
	task automatic scan_frame();
		for (int c = 0; c < COLS; c++)
			send_command(FUNC_SCAN, 8'h00, 8'h00, 1'b0, 8'h00);
	endtask

	// Random command mix: mostly dot writes and scans, some fills, a
	// few out-of-range dots and unused selectors.
	task automatic random_command();
		int pick;
		logic [1:0] unused_func;
		pick = $urandom_range(0, 99);
		unused_func = 2'd3;
		if (pick < 40)
			send_command(FUNC_SET, 8'($urandom_range(0, COLS - 1)),
				8'($urandom_range(0, ROWS - 1)), 1'($urandom), 8'($urandom));
		else if (pick < 45)
			send_command(FUNC_SET, 8'($urandom), 8'($urandom), 1'($urandom),
				8'($urandom));
		else if (pick < 50)
			send_command(FUNC_FILL, 8'($urandom), 8'($urandom), 1'($urandom),
				8'($urandom));
		else if (pick < 52)
			send_command(unused_func, 8'($urandom), 8'($urandom), 1'($urandom),
				8'($urandom));
		else
			send_command(FUNC_SCAN, 8'($urandom), 8'($urandom), 1'($urandom),
				8'($urandom));
	endtask

	initial begin
		logic [31:0] maps [4];
		packet_board = new();
		packet_board.reset_state();
		no_idle = 1'b0;
		arst_n = 1'b0;
		item_in.valid = 1'b0;
		item_in.func = FUNC_SET;
		item_in.x = '0;
		item_in.y = '0;
		item_in.state = 1'b0;
		item_in.fill_value = '0;
		cfg.valid = 1'b0;
		cfg.module_map = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: corner dots, out-of-range dots, the unused selector,
		// a quiet column, and two fills, all under the reset module map.
		send_command(FUNC_SCAN, 8'h00, 8'h00, 1'b0, 8'h00);
		send_command(FUNC_SET, 8'd0, 8'd0, 1'b1, 8'h00);
		send_command(FUNC_SET, 8'd0, 8'd27, 1'b1, 8'h00);
		send_command(FUNC_SET, 8'd0, 8'd13, 1'b1, 8'h00);
		send_command(FUNC_SET, 8'd0, 8'd14, 1'b1, 8'h00);
		send_command(FUNC_SET, 8'd1, 8'd7, 1'b1, 8'h00);
		send_command(FUNC_SET, 8'd111, 8'd27, 1'b1, 8'h00);
		send_command(FUNC_SET, 8'd112, 8'd3, 1'b1, 8'h00);
		send_command(FUNC_SET, 8'd255, 8'd255, 1'b1, 8'hFF);
		send_command(FUNC_SET, 8'd5, 8'd28, 1'b1, 8'h00);
		send_command(2'd3, 8'hFF, 8'hFF, 1'b1, 8'hFF);
		send_command(FUNC_SCAN, 8'hFF, 8'hFF, 1'b1, 8'hFF);
		send_command(FUNC_SCAN, 8'h00, 8'h00, 1'b0, 8'h00);
		for (int c = 3; c < COLS; c++)
			send_command(FUNC_SCAN, 8'h00, 8'h00, 1'b0, 8'h00);
		// Clearing the dots again exercises packets with the dot state low.
		send_command(FUNC_SET, 8'd0, 8'd0, 1'b0, 8'h00);
		send_command(FUNC_FILL, 8'h00, 8'h00, 1'b0, 8'hA5);
		scan_frame();
		send_command(FUNC_FILL, 8'h00, 8'h00, 1'b0, 8'hFF);
		// The sender waits here until every predicted packet has come.
		drain_block();

		maps[0] = 32'h0000_0000;
		maps[1] = 32'hFFFF_FFFF;
		maps[2] = 32'h1928_3746;
		maps[3] = 32'($urandom);
		for (int phase = 0; phase < 4; phase++) begin
			write_module_map(maps[phase]);
			if (phase == 3)
				no_idle = 1'b1;
			for (int i = 0; i < 18; i++)
				random_command();
			drain_block();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (packet_board.errors == 0 && packet_board.pending_packets.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
